@@ rtl/core/txc_pkg.sv @@
package txc_pkg;

	// Default geometry
	localparam int SCREEN_WIDTH_DEF  = 1024;
	localparam int SCREEN_HEIGHT_DEF = 768;
	localparam int GLYPH_WIDTH_DEF   = 8;
	localparam int GLYPH_HEIGHT_DEF  = 16;
	localparam int PROMPT_GUARD_DEF  = 64;

	// Field widths
	localparam int ACT_W    = 2;
	localparam int POS_W    = 10;
	localparam int CHAR_W   = 8;
	localparam int COLOR_W  = 24;
	localparam int SCALE_W  = 4;
	localparam int ROWS_W   = 8;
	localparam int CFG_IDX_W = 2;

	// Result actions
	localparam logic [ACT_W-1:0] ACT_PAINT  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_BOX    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_SCROLL = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BG     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FG     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CUR_EN = 2'd3;

	// Register reset values
	localparam logic [SCALE_W-1:0] SCALE_RST = 4'd1;
	localparam logic [COLOR_W-1:0] BG_RST    = 24'h000000;
	localparam logic [COLOR_W-1:0] FG_RST    = 24'h04C0CC;

	// Scale limits
	localparam logic [SCALE_W-1:0] SCALE_MIN = 4'd1;
	localparam logic [SCALE_W-1:0] SCALE_MAX = 4'd8;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_BS        = 8'd8;
	localparam logic [CHAR_W-1:0] CH_NL        = 8'd10;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PRINT_MAX = 8'h80;
	localparam logic [CHAR_W-1:0] CH_NONE      = 8'h00;

	typedef struct packed {
		logic [ACT_W-1:0]   action;
		logic [POS_W-1:0]   pos_x;
		logic [POS_W-1:0]   pos_y;
		logic [CHAR_W-1:0]  glyph;
		logic [COLOR_W-1:0] fg_out;
		logic [COLOR_W-1:0] bg_out;
		logic [SCALE_W-1:0] scale_out;
		logic [ROWS_W-1:0]  scroll_rows;
		logic               last;
	} res_t;

endpackage

@@ rtl/core/txc_if.sv @@
// Input channel: character code or blink tick
interface txc_cmd_if import txc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              func;
	logic [CHAR_W-1:0] char_code;

	modport source (output valid, func, char_code, input ready);
	modport sink (input valid, func, char_code, output ready);
endinterface

// Result channel: draw commands
interface txc_res_if import txc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ACT_W-1:0]   action;
	logic [POS_W-1:0]   pos_x;
	logic [POS_W-1:0]   pos_y;
	logic [CHAR_W-1:0]  glyph;
	logic [COLOR_W-1:0] fg_out;
	logic [COLOR_W-1:0] bg_out;
	logic [SCALE_W-1:0] scale_out;
	logic [ROWS_W-1:0]  scroll_rows;
	logic               last;

	modport source (output valid, action, pos_x, pos_y, glyph, fg_out, bg_out,
		scale_out, scroll_rows, last, input ready);
	modport sink (input valid, action, pos_x, pos_y, glyph, fg_out, bg_out,
		scale_out, scroll_rows, last, output ready);
endinterface

// Configuration write channel
interface txc_cfg_if import txc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [COLOR_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/text_console_cursor_engine_core.sv @@
// A result is written into the result queue when its transaction is accepted.
// Throughput: one input transaction per cycle while the queue has room; the queue
// drains one result per cycle while res.ready is high, and an input giving two
// results (wrap or newline with scroll) takes two queue entries. Input is taken
// while the queue has room for two results. Reset (arst_n low, asynchronous)
// clears cursor, blink phase, queue and restores the register defaults.
module text_console_cursor_engine_core import txc_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
	parameter int GLYPH_WIDTH   = GLYPH_WIDTH_DEF,
	parameter int GLYPH_HEIGHT  = GLYPH_HEIGHT_DEF,
	parameter int PROMPT_GUARD  = PROMPT_GUARD_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	txc_cmd_if.sink  cmd,
	txc_res_if.source res,
	txc_cfg_if.sink  cfg
);

	localparam int XW    = $clog2(SCREEN_WIDTH);
	localparam int YW    = $clog2(SCREEN_HEIGHT);
	localparam int SUMW  = $clog2(SCREEN_WIDTH + SCREEN_HEIGHT + 512);
	localparam int DEPTH = 4;
	localparam int PTRW  = $clog2(DEPTH);
	localparam int CNTW  = $clog2(DEPTH + 1);

	// Configuration registers
	logic [SCALE_W-1:0] scale_q;
	logic [COLOR_W-1:0] bg_q;
	logic [COLOR_W-1:0] fg_q;
	logic               cur_en_q;

	// Cursor state
	logic [XW-1:0] cursor_x_q;
	logic [YW-1:0] cursor_y_q;
	logic          blink_phase_q;

	// Result queue
	res_t            fifo_q [DEPTH];
	logic [PTRW-1:0] wr_ptr_q;
	logic [PTRW-1:0] rd_ptr_q;
	logic [CNTW-1:0] count_q;

	logic cmd_acc;
	logic res_pop;

	// Step logic
	logic [SCALE_W-1:0] scale_eff;
	logic [SUMW-1:0]    x_ext;
	logic [SUMW-1:0]    y_ext;
	logic [SUMW-1:0]    w_ext;
	logic [SUMW-1:0]    h_ext;
	logic [SUMW-1:0]    nx_x;
	logic [SUMW-1:0]    nx_y;
	logic               nx_phase;
	logic [1:0]         n_res;
	res_t               r0;
	res_t               r1;

	assign cfg.ready = 1'b1;
	assign cmd.ready = (count_q <= CNTW'(DEPTH - 2));
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign res_pop   = res.valid && res.ready;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= SCALE_RST;
			bg_q     <= BG_RST;
			fg_q     <= FG_RST;
			cur_en_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_SCALE:  scale_q  <= cfg.data[SCALE_W-1:0];
				REG_BG:     bg_q     <= cfg.data;
				REG_FG:     fg_q     <= cfg.data;
				REG_CUR_EN: cur_en_q <= cfg.data[0];
				default:    ;
			endcase
		end
	end

	// Clamp scale and size the cell
	always_comb begin
		if (scale_q == '0) begin
			scale_eff = SCALE_MIN;
		end else if (scale_q > SCALE_MAX) begin
			scale_eff = SCALE_MAX;
		end else begin
			scale_eff = scale_q;
		end
		w_ext = SUMW'(scale_eff) * SUMW'(GLYPH_WIDTH);
		h_ext = SUMW'(scale_eff) * SUMW'(GLYPH_HEIGHT);
		x_ext = SUMW'(cursor_x_q);
		y_ext = SUMW'(cursor_y_q);
	end

	// Decode the item, build results and the next cursor
	always_comb begin
		nx_x     = x_ext;
		nx_y     = y_ext;
		nx_phase = blink_phase_q;
		n_res    = 2'd0;

		r0.action      = ACT_PAINT;
		r0.pos_x       = x_ext[POS_W-1:0];
		r0.pos_y       = y_ext[POS_W-1:0];
		r0.glyph       = CH_SPACE;
		r0.fg_out      = bg_q;
		r0.bg_out      = bg_q;
		r0.scale_out   = scale_eff;
		r0.scroll_rows = '0;
		r0.last        = 1'b1;

		r1.action      = ACT_SCROLL;
		r1.pos_x       = '0;
		r1.pos_y       = '0;
		r1.glyph       = CH_NONE;
		r1.fg_out      = '0;
		r1.bg_out      = bg_q;
		r1.scale_out   = scale_eff;
		r1.scroll_rows = h_ext[ROWS_W-1:0];
		r1.last        = 1'b1;

		if (cmd.func) begin
			// blink tick
			if (cur_en_q) begin
				n_res     = 2'd1;
				r0.action = ACT_BOX;
				r0.glyph  = CH_NONE;
				r0.fg_out = blink_phase_q ? fg_q : bg_q;
				nx_phase  = ~blink_phase_q;
			end
		end else if (cmd.char_code == CH_NL) begin
			n_res = 2'd1;
			nx_x  = '0;
			if (y_ext + h_ext < SUMW'(SCREEN_HEIGHT)) begin
				nx_y = y_ext + h_ext;
			end else begin
				n_res   = 2'd2;
				r0.last = 1'b0;
			end
		end else if (cmd.char_code == CH_BS) begin
			n_res = 2'd1;
			if (x_ext > SUMW'(PROMPT_GUARD)) begin
				if (x_ext >= w_ext) begin
					nx_x = x_ext - w_ext;
				end else begin
					nx_y = (y_ext >= h_ext) ? y_ext - h_ext : '0;
					nx_x = (SUMW'(SCREEN_WIDTH) >= w_ext) ?
						SUMW'(SCREEN_WIDTH) - w_ext : '0;
				end
			end
		end else if (cmd.char_code >= CH_SPACE && cmd.char_code <= CH_PRINT_MAX) begin
			n_res     = 2'd1;
			r0.glyph  = cmd.char_code;
			r0.fg_out = fg_q;
			if (x_ext + w_ext < SUMW'(SCREEN_WIDTH)) begin
				nx_x = x_ext + w_ext;
			end else if (y_ext + h_ext < SUMW'(SCREEN_HEIGHT)) begin
				nx_y = y_ext + h_ext;
				nx_x = '0;
			end else begin
				n_res   = 2'd2;
				r0.last = 1'b0;
				nx_x    = '0;
			end
		end
	end

	// Advance cursor state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q    <= '0;
			cursor_y_q    <= '0;
			blink_phase_q <= 1'b0;
		end else if (cmd_acc) begin
			cursor_x_q    <= nx_x[XW-1:0];
			cursor_y_q    <= nx_y[YW-1:0];
			blink_phase_q <= nx_phase;
		end
	end

	// Push results into the queue
	always_ff @(posedge clk) begin
		if (cmd_acc && n_res != 2'd0) begin
			fifo_q[wr_ptr_q] <= r0;
		end
		if (cmd_acc && n_res == 2'd2) begin
			fifo_q[wr_ptr_q + PTRW'(1)] <= r1;
		end
	end

	// Track queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (cmd_acc) begin
				wr_ptr_q <= wr_ptr_q + PTRW'(n_res);
			end
			if (res_pop) begin
				rd_ptr_q <= rd_ptr_q + PTRW'(1);
			end
			count_q <= count_q + (cmd_acc ? CNTW'(n_res) : CNTW'(0)) -
				(res_pop ? CNTW'(1) : CNTW'(0));
		end
	end

	// Drive the head of the queue
	assign res.valid       = (count_q != '0);
	assign res.action      = fifo_q[rd_ptr_q].action;
	assign res.pos_x       = fifo_q[rd_ptr_q].pos_x;
	assign res.pos_y       = fifo_q[rd_ptr_q].pos_y;
	assign res.glyph       = fifo_q[rd_ptr_q].glyph;
	assign res.fg_out      = fifo_q[rd_ptr_q].fg_out;
	assign res.bg_out      = fifo_q[rd_ptr_q].bg_out;
	assign res.scale_out   = fifo_q[rd_ptr_q].scale_out;
	assign res.scroll_rows = fifo_q[rd_ptr_q].scroll_rows;
	assign res.last        = fifo_q[rd_ptr_q].last;

	// Checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(DEPTH))
		else $error("result queue overfilled");

	a_cursor_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		SUMW'(cursor_x_q) < SUMW'(SCREEN_WIDTH))
		else $error("cursor column beyond screen");

	a_cursor_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		SUMW'(cursor_y_q) < SUMW'(SCREEN_HEIGHT))
		else $error("cursor row beyond screen");

	a_tick_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && cmd.func && !cur_en_q |=> $stable(blink_phase_q))
		else $error("disabled tick changed blink phase");

endmodule

@@ test/text_console_cursor_engine_core_tb.sv @@
`timescale 1ns / 1ps

module text_console_cursor_engine_core_tb;
	import txc_pkg::*;

	localparam int SCR_W   = SCREEN_WIDTH_DEF;
	localparam int SCR_H   = SCREEN_HEIGHT_DEF;
	localparam int GLYPH_W = GLYPH_WIDTH_DEF;
	localparam int GLYPH_H = GLYPH_HEIGHT_DEF;
	localparam int GUARD   = PROMPT_GUARD_DEF;

	localparam logic FN_CHAR = 1'b0;
	localparam logic FN_TICK = 1'b1;

	localparam int DRAIN_CYCLES = 4;
	localparam int LONG_HOLD    = 80;
	localparam int IDLE_LIMIT   = 2000;
	localparam int RAND_PHASES  = 9;
	localparam int PHASE_KEYS   = 92;

	typedef struct packed {
		logic              func;
		logic [CHAR_W-1:0] code;
	} key_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Signals driven by the testbench, known from time zero
	logic               tx_valid = 1'b0;
	logic               tx_func  = 1'b0;
	logic [CHAR_W-1:0]  tx_code  = '0;
	logic               rx_ready = 1'b0;
	logic               wr_valid = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [COLOR_W-1:0] wr_data  = '0;

	txc_cmd_if cmd_if ();
	txc_res_if res_if ();
	txc_cfg_if cfg_if ();

	assign cmd_if.valid     = tx_valid;
	assign cmd_if.func      = tx_func;
	assign cmd_if.char_code = tx_code;
	assign res_if.ready     = rx_ready;
	assign cfg_if.valid     = wr_valid;
	assign cfg_if.index     = wr_index;
	assign cfg_if.data      = wr_data;

	text_console_cursor_engine_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	// Keys waiting to be sent and draw commands waiting to come back
	key_item_t key_q[$];
	res_t      draw_q[$];

	// Shadow of the registers and the cursor state
	logic [SCALE_W-1:0] sh_scale = SCALE_RST;
	logic [COLOR_W-1:0] sh_bg    = BG_RST;
	logic [COLOR_W-1:0] sh_fg    = FG_RST;
	logic               sh_en    = 1'b0;
	int                 cur_x    = 0;
	int                 cur_y    = 0;
	logic               blink    = 1'b0;

	// Handshake flags seen at the last rising edge
	logic cmd_taken = 1'b0;
	logic res_taken = 1'b0;
	logic cfg_taken = 1'b0;

	// Idling controls set by the stimulus
	logic tx_gaps_on   = 1'b1;
	logic rx_stalls_on = 1'b1;
	int   hold_req     = 0;
	int   hold_ack     = 0;
	int   rx_hold      = 0;
	int   rx_stall     = 0;
	int   tx_gap       = 0;

	int mismatch_cnt  = 0;
	int keys_sent     = 0;
	int draws_checked = 0;
	int scrolls_seen  = 0;
	int boxes_seen    = 0;
	int settings_cnt  = 0;
	int idle_cycles   = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic res_t draw_cmd(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] x,
			input logic [POS_W-1:0] y, input logic [CHAR_W-1:0] ch, input logic [COLOR_W-1:0] fg,
			input logic [COLOR_W-1:0] bg, input logic [SCALE_W-1:0] s, input logic [ROWS_W-1:0] rows);
		res_t r;
		r.action      = act;
		r.pos_x       = x;
		r.pos_y       = y;
		r.glyph       = ch;
		r.fg_out      = fg;
		r.bg_out      = bg;
		r.scale_out   = s;
		r.scroll_rows = rows;
		r.last        = 1'b0;
		return r;
	endfunction

	// Work out the draw commands one key or tick causes and advance the cursor
	task automatic predict_draw(input key_item_t k);
		logic [SCALE_W-1:0] s;
		int w;
		int h;
		int n;
		res_t d0;
		res_t d1;
		if (sh_scale == 0)
			s = SCALE_MIN;
		else if (sh_scale > SCALE_MAX)
			s = SCALE_MAX;
		else
			s = sh_scale;
		w = s * GLYPH_W;
		h = s * GLYPH_H;
		n = 0;
		d0 = '0;
		d1 = draw_cmd(ACT_SCROLL, '0, '0, CH_NONE, '0, sh_bg, s, ROWS_W'(h));
		if (k.func == FN_TICK) begin
			if (sh_en) begin
				d0 = draw_cmd(ACT_BOX, POS_W'(cur_x), POS_W'(cur_y), CH_NONE,
					blink ? sh_fg : sh_bg, sh_bg, s, '0);
				blink = ~blink;
				n = 1;
			end
		end else if (k.code == CH_NL) begin
			d0 = draw_cmd(ACT_PAINT, POS_W'(cur_x), POS_W'(cur_y), CH_SPACE, sh_bg, sh_bg,
				s, '0);
			n = 1;
			cur_x = 0;
			if (cur_y + h < SCR_H)
				cur_y += h;
			else
				n = 2;
		end else if (k.code == CH_BS) begin
			d0 = draw_cmd(ACT_PAINT, POS_W'(cur_x), POS_W'(cur_y), CH_SPACE, sh_bg, sh_bg,
				s, '0);
			n = 1;
			// hold the cursor inside the prompt area
			if (cur_x > GUARD) begin
				if (cur_x - w >= 0) begin
					cur_x -= w;
				end else begin
					cur_y = (cur_y >= h) ? cur_y - h : 0;
					cur_x = (SCR_W - w >= 0) ? SCR_W - w : 0;
				end
			end
		end else if (k.code >= CH_SPACE && k.code <= CH_PRINT_MAX) begin
			d0 = draw_cmd(ACT_PAINT, POS_W'(cur_x), POS_W'(cur_y), k.code, sh_fg, sh_bg,
				s, '0);
			n = 1;
			if (cur_x + w < SCR_W) begin
				cur_x += w;
			end else if (cur_y + h < SCR_H) begin
				cur_y += h;
				cur_x = 0;
			end else begin
				n = 2;
				cur_x = 0;
			end
		end
		if (n == 1)
			d0.last = 1'b1;
		if (n >= 1)
			draw_q.push_back(d0);
		if (n == 2) begin
			d1.last = 1'b1;
			draw_q.push_back(d1);
		end
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			mismatch_cnt++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
		end
	endtask

	// Drive the key channel: hold until taken, then idle for any random gap and offer the next
	always @(negedge clk) begin
		key_item_t k;
		if (arst_n) begin
			if (tx_valid && !cmd_taken) begin
				// hold the current transaction
			end else if (tx_gap > 0) begin
				tx_valid <= 1'b0;
				tx_gap <= tx_gap - 1;
			end else if (key_q.size() > 0) begin
				k = key_q.pop_front();
				tx_valid <= 1'b1;
				tx_func <= k.func;
				tx_code <= k.code;
				tx_gap <= tx_gaps_on ? int'($urandom_range(0, 4)) : 0;
			end else begin
				tx_valid <= 1'b0;
			end
		end
	end

	// Drive ready on the draw channel: long holds on request, short stalls per result
	always @(negedge clk) begin
		int d;
		d = (res_taken && rx_stalls_on) ? int'($urandom_range(0, 4)) : 0;
		if (arst_n) begin
			if (hold_req != hold_ack) begin
				hold_ack <= hold_req;
				rx_hold <= LONG_HOLD;
				rx_ready <= 1'b0;
			end else if (rx_hold > 0) begin
				rx_hold <= rx_hold - 1;
				rx_ready <= 1'b0;
			end else if (d > 0) begin
				rx_stall <= d - 1;
				rx_ready <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall <= rx_stall - 1;
				rx_ready <= 1'b0;
			end else begin
				rx_ready <= 1'b1;
			end
		end
	end

	// Sample all channels: predict on keys, track registers, check draw commands
	always @(posedge clk) begin
		res_t got;
		res_t want;
		cmd_taken <= arst_n && cmd_if.valid && cmd_if.ready;
		res_taken <= arst_n && res_if.valid && res_if.ready;
		cfg_taken <= arst_n && cfg_if.valid && cfg_if.ready;
		if (arst_n) begin
			if (cmd_if.valid && cmd_if.ready)
				predict_draw('{func: cmd_if.func, code: cmd_if.char_code});
			if (cfg_if.valid && cfg_if.ready) begin
				case (cfg_if.index)
					REG_SCALE:  sh_scale = cfg_if.data[SCALE_W-1:0];
					REG_BG:     sh_bg = cfg_if.data;
					REG_FG:     sh_fg = cfg_if.data;
					REG_CUR_EN: sh_en = cfg_if.data[0];
					default: ;
				endcase
			end
			if (res_if.valid && res_if.ready) begin
				got.action      = res_if.action;
				got.pos_x       = res_if.pos_x;
				got.pos_y       = res_if.pos_y;
				got.glyph       = res_if.glyph;
				got.fg_out      = res_if.fg_out;
				got.bg_out      = res_if.bg_out;
				got.scale_out   = res_if.scale_out;
				got.scroll_rows = res_if.scroll_rows;
				got.last        = res_if.last;
				if (draw_q.size() == 0) begin
					mismatch_cnt++;
					$display("%0t: unexpected draw command, expected none, actual action %0d",
						$time, got.action);
				end else begin
					want = draw_q.pop_front();
					check_field("action", 32'(want.action), 32'(got.action));
					check_field("pos_x", 32'(want.pos_x), 32'(got.pos_x));
					check_field("pos_y", 32'(want.pos_y), 32'(got.pos_y));
					check_field("glyph", 32'(want.glyph), 32'(got.glyph));
					check_field("fg_out", 32'(want.fg_out), 32'(got.fg_out));
					check_field("bg_out", 32'(want.bg_out), 32'(got.bg_out));
					check_field("scale_out", 32'(want.scale_out), 32'(got.scale_out));
					check_field("scroll_rows", 32'(want.scroll_rows),
						32'(got.scroll_rows));
					check_field("last", 32'(want.last), 32'(got.last));
					draws_checked++;
					if (want.action == ACT_SCROLL)
						scrolls_seen++;
					if (want.action == ACT_BOX)
						boxes_seen++;
				end
			end
		end
	end

	// End the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic push_key(input logic func, input logic [CHAR_W-1:0] code);
		key_q.push_back('{func: func, code: code});
		keys_sent++;
	endtask

	function automatic key_item_t random_key(input int nl_pct);
		key_item_t k;
		int unsigned r;
		r = $urandom_range(0, 99);
		k.func = FN_CHAR;
		k.code = CH_NONE;
		if (r < nl_pct) begin
			k.code = CH_NL;
		end else if (r < nl_pct + 10) begin
			k.code = CH_BS;
		end else if (r < nl_pct + 22) begin
			k.func = FN_TICK;
			k.code = CHAR_W'($urandom_range(0, 255));
		end else if (r < nl_pct + 28) begin
			// unprintable noise that the block drops
			do
				k.code = CHAR_W'($urandom_range(0, 255));
			while (k.code == CH_NL || k.code == CH_BS ||
				(k.code >= CH_SPACE && k.code <= CH_PRINT_MAX));
		end else begin
			k.code = CHAR_W'($urandom_range(CH_SPACE, CH_PRINT_MAX));
		end
		return k;
	endfunction

	// Wait until every key is taken and every draw command is back
	task automatic wait_drained();
		do
			@(posedge clk);
		while (key_q.size() != 0 || tx_valid || draw_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] val);
		@(negedge clk);
		wr_valid <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		while (!cfg_taken)
			@(negedge clk);
		wr_valid <= 1'b0;
	endtask

	task automatic apply_settings(input logic [SCALE_W-1:0] sc, input logic [COLOR_W-1:0] bg,
			input logic [COLOR_W-1:0] fg, input logic en);
		logic [COLOR_W-1:0] d;
		d = COLOR_W'($urandom);
		d[SCALE_W-1:0] = sc;
		write_reg(REG_SCALE, d);
		write_reg(REG_BG, bg);
		write_reg(REG_FG, fg);
		d = COLOR_W'($urandom);
		d[0] = en;
		write_reg(REG_CUR_EN, d);
		settings_cnt++;
	endtask

	initial begin
		int ph;
		int i;
		logic [SCALE_W-1:0] sc;
		logic [COLOR_W-1:0] bg;
		logic [COLOR_W-1:0] fg;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: dropped tick, printable bounds, noise, guarded and free backspace
		push_key(FN_TICK, CH_NONE);
		push_key(FN_CHAR, CH_SPACE);
		push_key(FN_CHAR, CH_PRINT_MAX);
		push_key(FN_CHAR, 8'h41);
		push_key(FN_CHAR, CH_BS);
		push_key(FN_CHAR, 8'h00);
		push_key(FN_CHAR, 8'hFF);
		push_key(FN_CHAR, 8'h81);
		push_key(FN_CHAR, 8'h1F);
		for (i = 0; i < 6; i++)
			push_key(FN_CHAR, 8'h7E);
		push_key(FN_CHAR, CH_BS);
		push_key(FN_CHAR, CH_BS);
		push_key(FN_CHAR, CH_NL);
		wait_drained();

		// Largest scale, extreme colours: both blink phases, then newline down to a scroll
		apply_settings(SCALE_MAX, 24'hFFFFFF, 24'h000000, 1'b1);
		push_key(FN_TICK, 8'hFF);
		push_key(FN_TICK, CH_NONE);
		for (i = 0; i < 6; i++)
			push_key(FN_CHAR, CH_NL);
		push_key(FN_CHAR, CH_BS);

		// Random phases, each under its own register setting
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			wait_drained();
			case (ph)
				0: sc = 4'd0;
				1: sc = 4'd15;
				2: sc = SCALE_MIN;
				3: sc = SCALE_MAX;
				4: sc = 4'd9;
				5: sc = 4'd2;
				default: sc = SCALE_W'($urandom_range(0, 15));
			endcase
			bg = (ph == 0) ? 24'h000000 : (ph == 1) ? 24'hFFFFFF : 24'($urandom);
			fg = (ph == 0) ? 24'hFFFFFF : (ph == 1) ? 24'h000000 : 24'($urandom);
			apply_settings(sc, bg, fg, (ph % 4) != 3);
			tx_gaps_on <= (ph % 3) != 2;
			rx_stalls_on <= (ph % 3) != 1;
			// stall the draw side for a long stretch while keys keep coming
			if (ph == 2)
				hold_req <= hold_req + 1;
			for (i = 0; i < PHASE_KEYS; i++)
				key_q.push_back(random_key((ph >= 6) ? 30 : 10));
			keys_sent += PHASE_KEYS;
		end
		wait_drained();

		$display("Sent %0d key and tick transactions under %0d register settings.",
			keys_sent, settings_cnt);
		$display("Checked %0d draw commands, %0d of them scrolls and %0d cursor boxes.",
			draws_checked, scrolls_seen, boxes_seen);
		if (mismatch_cnt == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
